// ----- src/pwcf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pulse width capture filter.
// Holds the register indexes, the fixed field widths and the result entry type.
package pwcf_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_FILTER_FACTOR = 2'd0;
   localparam logic [1:0] CSR_MAX_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT       = 2'd2;

   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 22;
   localparam int FACTOR_W      = 17;
   localparam int MAX_WIDTH_W   = 16;
   localparam int TIMEOUT_W     = 22;
   localparam int AVG_W         = 24;
   localparam int RAW_W         = 16;

   localparam logic [FACTOR_W-1:0]    FACTOR_ONE    = 17'h10000;
   localparam logic [FACTOR_W-1:0]    FACTOR_RESET  = 17'd58982;
   localparam logic [MAX_WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2500;
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET = 22'd0;
   localparam int                     AVG_RESET_US  = 1500;
   localparam int                     ROUND_HALF    = 32768;

   typedef struct packed {
      logic [AVG_W-1:0] filtered_width;
      logic [RAW_W-1:0] raw_width;
      logic             from_timeout;
   } rsp_entry_type;

endpackage

// ----- src/pwcf_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pulse width capture filter.
// Depends on pwcf_pkg for the field widths.
interface pwcf_req_if import pwcf_pkg::*; ();
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

interface pwcf_rsp_if import pwcf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [AVG_W-1:0] filtered_width;
   logic [RAW_W-1:0] raw_width;
   logic             from_timeout;

   modport source (output valid, output filtered_width, output raw_width,
                   output from_timeout, input ready);
   modport sink (input valid, input filtered_width, input raw_width,
                 input from_timeout, output ready);
endinterface

// ----- src/pulse_width_capture_filter.sv -----
`timescale 1ns / 1ps
// Pulse width capture filter top level: one pin sample per transfer.
// Depends on pwcf_pkg and the channel interfaces in pwcf_if.sv.
//
// Takes one pin sample per transfer and accepts a new sample every clock cycle
// while ready is high. A sample is registered at its transfer and processed in
// the following cycle; the result, if any, is written into the result queue at
// the end of that cycle and is shown on the response channel from there. The pace
// is set by the averaging update, two 17x24 multiplies and an add done in the
// processing cycle, since the next sample may need the updated average. Results
// collect in a four entry queue, so samples keep flowing while results wait to
// be taken; the request side stalls only when the queue could overflow.
module pulse_width_capture_filter
   import pwcf_pkg::*;
#(
   parameter int COUNT_BITS = 22,
   parameter int FRAC_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   pwcf_req_if.sink               req_chan,
   pwcf_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CMP_W    = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
   localparam int SAMPLE_W = RAW_W + FRAC_BITS;
   localparam int MUL_W    = (SAMPLE_W > AVG_W) ? SAMPLE_W : AVG_W;
   localparam int SUM_W    = FACTOR_W + MUL_W + 1;
   localparam int DEPTH    = 4;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int OCC_W    = PTR_W + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
   localparam logic [AVG_W-1:0]      AVG_RESET = AVG_W'(AVG_RESET_US << FRAC_BITS);
   localparam logic [AVG_W-1:0]      AVG_MAX   = {AVG_W{1'b1}};

   // configuration
   logic [FACTOR_W-1:0]    filter_factor_ff;
   logic [MAX_WIDTH_W-1:0] max_width_ff;
   logic [TIMEOUT_W-1:0]   timeout_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_pin_ff;

   // measurement state
   logic [COUNT_BITS-1:0] tick_count_ff, tick_count_in;
   logic                  prev_level_ff, prev_level_in;
   logic [AVG_W-1:0]      avg_ff, avg_in;

   // result queue
   rsp_entry_type         fifo_mem [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]      occ_ff, occ_in;

   logic                  req_xfer, rsp_xfer;
   logic [COUNT_BITS-1:0] width_c;
   logic [CMP_W-1:0]      width_ext;
   logic                  pin_edge, timed, evt_hit, qualify, push;
   logic [FACTOR_W-1:0]   weight;
   logic [SAMPLE_W-1:0]   sample;
   logic [SUM_W-1:0]      prod_a, prod_b, sum;
   logic [AVG_W-1:0]      blend_q;
   rsp_entry_type         push_entry;
   logic [OCC_W:0]        in_flight;

   // Counting the sample still in the input register keeps the queue safe
   // without a combinational path from the response side.
   assign in_flight      = (OCC_W+1)'(occ_ff) + (OCC_W+1)'(in_valid_ff);
   assign req_chan.ready = in_flight < (OCC_W+1)'(DEPTH);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;
   assign in_valid_in    = req_xfer;

   always_comb begin
      width_c   = (tick_count_ff == COUNT_TOP) ? tick_count_ff : tick_count_ff + 1'b1;
      width_ext = CMP_W'(width_c);
      pin_edge  = in_pin_ff != prev_level_ff;
      timed     = (timeout_ff != '0) && (width_ext >= CMP_W'(timeout_ff));
      evt_hit   = in_valid_ff && (pin_edge || timed);
      qualify   = (width_ext < CMP_W'(max_width_ff)) && !in_pin_ff;
      push      = evt_hit && qualify;

      // weights above one act as one
      weight  = (filter_factor_ff > FACTOR_ONE) ? FACTOR_ONE : filter_factor_ff;
      sample  = SAMPLE_W'(width_ext[RAW_W-1:0]) << FRAC_BITS;
      prod_a  = SUM_W'(weight) * SUM_W'(avg_ff);
      prod_b  = SUM_W'(FACTOR_ONE - weight) * SUM_W'(sample);
      sum     = prod_a + prod_b + SUM_W'(ROUND_HALF);
      blend_q = (|sum[SUM_W-1:16+AVG_W]) ? AVG_MAX : sum[16+AVG_W-1:16];

      push_entry.filtered_width = blend_q;
      push_entry.raw_width      = width_ext[RAW_W-1:0];
      push_entry.from_timeout   = !pin_edge;

      tick_count_in = tick_count_ff;
      prev_level_in = prev_level_ff;
      avg_in        = avg_ff;
      if (in_valid_ff) begin
         prev_level_in = in_pin_ff;
         tick_count_in = evt_hit ? '0 : width_c;
         if (push) begin
            avg_in = blend_q;
         end
      end

      occ_in = occ_ff + OCC_W'(push) - OCC_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_factor_ff <= FACTOR_RESET;
         max_width_ff     <= MAX_WIDTH_RESET;
         timeout_ff       <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_FACTOR: filter_factor_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_MAX_WIDTH:     max_width_ff     <= csr_wdata[MAX_WIDTH_W-1:0];
            CSR_TIMEOUT:       timeout_ff       <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         tick_count_ff <= '0;
         prev_level_ff <= 1'b0;
         avg_ff        <= AVG_RESET;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         occ_ff        <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         tick_count_ff <= tick_count_in;
         prev_level_ff <= prev_level_in;
         avg_ff        <= avg_in;
         occ_ff        <= occ_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_pin_ff <= req_chan.pin_level;
      end
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign rsp_chan.valid          = occ_ff != '0;
   assign rsp_chan.filtered_width = fifo_mem[rd_ptr_ff].filtered_width;
   assign rsp_chan.raw_width      = fifo_mem[rd_ptr_ff].raw_width;
   assign rsp_chan.from_timeout   = fifo_mem[rd_ptr_ff].from_timeout;

   // queue never overfills, given the credit check on the request side
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("result queue overflow");

   // results only on a low pin with a processed sample
   a_push_src: assert property (@(posedge clock) disable iff (reset)
      push |-> (in_valid_ff && !in_pin_ff))
      else $error("result without a falling-level sample");

   // every event restarts the interval count
   a_evt_clear: assert property (@(posedge clock) disable iff (reset)
      evt_hit |=> (tick_count_ff == '0))
      else $error("counter not cleared after event");

   // the average moves only together with an emitted result
   a_avg_hold: assert property (@(posedge clock) disable iff (reset)
      !push |=> $stable(avg_ff))
      else $error("average changed without a result");

endmodule
